// ===== rtl/sac_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sac_pkg: shared types and constants of the lru tag store
// widths of item fields, mode codes, controller states and command struct
// ----------------------------------------------------------------------------
package sac_pkg;

  localparam int unsigned DefSets  = 64;
  localparam int unsigned DefWays  = 8;
  localparam int unsigned AddrW    = 42;
  localparam int unsigned StampW   = 48;
  localparam int unsigned LocW     = 9;
  localparam int unsigned ModeW    = 2;
  localparam int unsigned InvW     = 2;

  typedef enum logic [1:0] {
    MODE_READ  = 2'd0,
    MODE_WRITE = 2'd1,
    MODE_INVAL = 2'd2,
    MODE_FILL  = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    INV_NONE  = 2'd0,
    INV_CLEAN = 2'd1,
    INV_DIRTY = 2'd2
  } inv_e;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_READ = 2'd1,
    ST_EXEC = 2'd2
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic capture;  // latch item, issue set read
    logic execute;  // compare, pick, write back, emit result
  } sac_cmd_t;

endpackage

// ===== rtl/sac_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sac_ram: generic simple dual-port ram
// one write port, one read port, registered read data
// ----------------------------------------------------------------------------
module sac_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
    rdata_o <= mem[raddr_i];
  end

endmodule

// ===== rtl/sac_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sac_ctrl: controller
// sequences capture, set read and execute for one item at a time
// ----------------------------------------------------------------------------
module sac_ctrl
  import sac_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start_i,
  output logic     busy_o,
  output sac_cmd_t cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= ST_IDLE;
    else         state_q <= state_d;
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (start_i) state_d = ST_READ;
      ST_READ: state_d = ST_EXEC;
      ST_EXEC: state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    busy_o        = 1'b1;
    cmd_o.capture = 1'b0;
    cmd_o.execute = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        busy_o        = 1'b0;
        cmd_o.capture = start_i;
      end
      ST_READ: ;
      ST_EXEC: cmd_o.execute = 1'b1;
      default: ;
    endcase
  end

endmodule

// ===== rtl/sac_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sac_dp: datapath
// way memories, valid bits, access counter, compare, victim pick, result regs
// ----------------------------------------------------------------------------
module sac_dp
  import sac_pkg::*;
#(
  parameter int unsigned Sets = DefSets,
  parameter int unsigned Ways = DefWays
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  sac_cmd_t          cmd_i,
  input  logic [ModeW-1:0]  mode_i,
  input  logic [AddrW-1:0]  line_address_i,
  input  logic              fill_dirty_i,
  input  logic [StampW-1:0] fill_stamp_i,
  output logic              done_o,
  output logic              found_o,
  output logic [LocW-1:0]   location_o,
  output logic              miss_o,
  output logic [StampW-1:0] access_stamp_o,
  output logic [InvW-1:0]   invalidate_status_o,
  output logic              evicted_o,
  output logic [AddrW-1:0]  evicted_address_o,
  output logic              evicted_dirty_o,
  output logic [StampW-1:0] evicted_stamp_o
);

  localparam int unsigned SetW  = (Sets > 1) ? $clog2(Sets) : 1;
  localparam int unsigned WayW  = (Ways > 1) ? $clog2(Ways) : 1;
  localparam int unsigned EntW  = 1 + AddrW + StampW;
  localparam int unsigned LineW = $clog2(Sets * Ways + 1);

  // captured item
  logic [ModeW-1:0]  mode_q;
  logic [AddrW-1:0]  addr_q;
  logic              fdirty_q;
  logic [StampW-1:0] fstamp_q;
  logic [SetW-1:0]   set_q;
  logic [SetW-1:0]   set_in;

  logic [StampW-1:0] cnt_q, cnt_d;
  logic [Ways-1:0]   valid_q [Sets];
  logic [Ways-1:0]   vset_q;

  logic [EntW-1:0]   rdata [Ways];
  logic [Ways-1:0]   we;
  logic [EntW-1:0]   wdata;

  // set index: address modulo sets
  always_comb begin
    set_in = '0;
    if (Sets > 1) set_in = SetW'(line_address_i % Sets);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      mode_q   <= mode_i;
      addr_q   <= line_address_i;
      fdirty_q <= fill_dirty_i;
      fstamp_q <= fill_stamp_i;
      set_q    <= set_in;
    end
  end

  // valid bits of the set, read alongside the way memories
  always_ff @(posedge clk_i) begin
    vset_q <= valid_q[set_q];
  end

  for (genvar w = 0; w < Ways; w++) begin : g_way
    sac_ram #(.Width(EntW), .Depth(Sets)) u_ram (
      .clk_i   (clk_i),
      .we_i    (we[w]),
      .waddr_i (set_q),
      .wdata_i (wdata),
      .raddr_i (set_q),
      .rdata_o (rdata[w])
    );
  end

  // compare and victim selection
  logic [Ways-1:0]   vset;
  logic [Ways-1:0]   hitv;
  logic              hit;
  logic [WayW-1:0]   hway;
  logic              any_inv;
  logic [WayW-1:0]   iway;
  logic [WayW-1:0]   oway;
  logic [StampW-1:0] ostamp;
  logic [WayW-1:0]   slot;
  logic [LocW-1:0]   hloc;
  logic [LineW-1:0]  lfull;

  always_comb begin
    vset    = vset_q;
    hit     = 1'b0;
    hway    = '0;
    any_inv = 1'b0;
    iway    = '0;
    oway    = '0;
    ostamp  = rdata[0][StampW-1:0];
    for (int w = Ways - 1; w >= 0; w--) begin
      hitv[w] = vset[w] && (rdata[w][AddrW+StampW-1:StampW] == addr_q);
      if (hitv[w]) begin
        hit  = 1'b1;
        hway = WayW'(w);
      end
      if (!vset[w]) begin
        any_inv = 1'b1;
        iway    = WayW'(w);
      end
    end
    for (int w = 1; w < Ways; w++) begin
      if (rdata[w][StampW-1:0] < ostamp) begin
        ostamp = rdata[w][StampW-1:0];
        oway   = WayW'(w);
      end
    end
    slot  = hit ? hway : (any_inv ? iway : oway);
    lfull = LineW'(set_q) * LineW'(Ways) + LineW'(hway);
    hloc  = hit ? LocW'(lfull) : '0;
  end

  logic is_acc;
  assign is_acc = (mode_q == MODE_READ) || (mode_q == MODE_WRITE);
  assign cnt_d  = cnt_q + StampW'(1);

  // write-back of the touched way
  always_comb begin
    we    = '0;
    wdata = rdata[hway];
    if (cmd_i.execute) begin
      if (is_acc) begin
        if (hit) begin
          we[hway] = 1'b1;
          wdata    = {rdata[hway][EntW-1] | (mode_q == MODE_WRITE),
                      rdata[hway][AddrW+StampW-1:StampW], cnt_d};
        end
      end else if (mode_q == MODE_FILL) begin
        we[slot] = 1'b1;
        wdata    = {fdirty_q, addr_q, fstamp_q};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_o <= 1'b0;
      for (int s = 0; s < Sets; s++) valid_q[s] <= '0;
    end else begin
      done_o <= cmd_i.execute;
      if (cmd_i.execute) begin
        if (is_acc) cnt_q <= cnt_d;
        if (mode_q == MODE_INVAL && hit) valid_q[set_q][hway] <= 1'b0;
        if (mode_q == MODE_FILL) valid_q[set_q][slot] <= 1'b1;
      end
    end
  end

  // result registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.execute) begin
      found_o             <= hit;
      location_o          <= hloc;
      miss_o              <= is_acc && !hit;
      access_stamp_o      <= is_acc ? cnt_d : '0;
      invalidate_status_o <= INV_NONE;
      if (mode_q == MODE_INVAL && hit)
        invalidate_status_o <= rdata[hway][EntW-1] ? INV_DIRTY : INV_CLEAN;
      evicted_o         <= 1'b0;
      evicted_address_o <= '0;
      evicted_dirty_o   <= 1'b0;
      evicted_stamp_o   <= '0;
      if (mode_q == MODE_FILL && !hit && !any_inv) begin
        evicted_o         <= 1'b1;
        evicted_address_o <= rdata[oway][AddrW+StampW-1:StampW];
        evicted_dirty_o   <= rdata[oway][EntW-1];
        evicted_stamp_o   <= rdata[oway][StampW-1:0];
      end
    end
  end

endmodule

// ===== rtl/set_assoc_cache_lru_tags_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// set_assoc_cache_lru_tags_core: lru tag store of a set-associative cache
// read/write access, invalidate and refill on a line address, timestamp lru
// ----------------------------------------------------------------------------
//  channel | handshake       | payload
//  --------+-----------------+-------------------------------------------
//  item in | start_i, busy_o | mode_i, line_address_i, fill_dirty_i,
//          |                 | fill_stamp_i
//  result  | done_o (strobe) | found_o, location_o, miss_o, access_stamp_o,
//          |                 | invalidate_status_o, evicted_*_o
//
// from start to the done strobe an item first addresses the way memories of
// the set, then waits for their registered read, then compares, picks the
// victim and writes the way back; a new item is taken the cycle after
// execute, so no new item is taken before the last one is through. valid
// bits live in flops and reset clears them at once, so there is no clearing
// pass. the receiver cannot stall.
module set_assoc_cache_lru_tags_core
  import sac_pkg::*;
#(
  parameter int unsigned Sets = DefSets,
  parameter int unsigned Ways = DefWays
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  output logic              busy_o,
  input  logic [ModeW-1:0]  mode_i,
  input  logic [AddrW-1:0]  line_address_i,
  input  logic              fill_dirty_i,
  input  logic [StampW-1:0] fill_stamp_i,
  output logic              done_o,
  output logic              found_o,
  output logic [LocW-1:0]   location_o,
  output logic              miss_o,
  output logic [StampW-1:0] access_stamp_o,
  output logic [InvW-1:0]   invalidate_status_o,
  output logic              evicted_o,
  output logic [AddrW-1:0]  evicted_address_o,
  output logic              evicted_dirty_o,
  output logic [StampW-1:0] evicted_stamp_o
);

  sac_cmd_t cmd;

  // sequencer
  sac_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .busy_o  (busy_o),
    .cmd_o   (cmd)
  );

  // tag memories, compare and result registers
  sac_dp #(.Sets(Sets), .Ways(Ways)) u_dp (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cmd_i               (cmd),
    .mode_i              (mode_i),
    .line_address_i      (line_address_i),
    .fill_dirty_i        (fill_dirty_i),
    .fill_stamp_i        (fill_stamp_i),
    .done_o              (done_o),
    .found_o             (found_o),
    .location_o          (location_o),
    .miss_o              (miss_o),
    .access_stamp_o      (access_stamp_o),
    .invalidate_status_o (invalidate_status_o),
    .evicted_o           (evicted_o),
    .evicted_address_o   (evicted_address_o),
    .evicted_dirty_o     (evicted_dirty_o),
    .evicted_stamp_o     (evicted_stamp_o)
  );

endmodule
